[design/apdi_pkg.sv]
// ----------------------------------------------------------------------------
// apdi_pkg
// Shared types and constants for the analog port device identifier.
// ----------------------------------------------------------------------------
package apdi_pkg;

  // Sample and window geometry.
  localparam int unsigned WINDOW = 8;
  localparam int unsigned MV_W   = 13;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned CNT_W  = 8;

  // Voltage levels in millivolts.
  localparam logic [MV_W-1:0] MV_FULL          = 13'd5000;
  localparam logic [MV_W-1:0] MV_SERIAL_SPREAD = 13'd2500;
  localparam logic [MV_W-1:0] MV_HIGH_LEVEL    = 13'd3000;
  localparam logic [MV_W-1:0] MV_FLAT          = 13'd500;
  localparam logic [MV_W-1:0] MV_LOW_LEVEL     = 13'd1000;
  localparam logic [MV_W-1:0] MV_MID_LEVEL     = 13'd2500;

  // Run counts.
  localparam logic [CNT_W-1:0] SERIAL_CONFIRM = 8'd2;
  localparam logic [CNT_W-1:0] CNT_MAX        = 8'd255;
  localparam logic [CNT_W-1:0] THRESH_RESET   = 8'd3;

  // Device classes, coded as on the result channel.
  typedef enum logic [2:0] {
    CLS_NONE   = 3'd0,
    CLS_SERIAL = 3'd1,
    CLS_TRAIN  = 3'd2,
    CLS_SIMPLE = 3'd3,
    CLS_LIGHT  = 3'd4
  } apdi_class_t;

  // Input transaction payload.
  typedef struct packed {
    logic [MV_W-1:0] ch0_mv;
    logic [MV_W-1:0] ch1_mv;
  } apdi_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic [2:0]       detected_class;
    logic             confirmed;
    logic             release_device;
    logic [CNT_W-1:0] match_count;
  } apdi_out_t;

  // Window extremes of both channels.
  typedef struct packed {
    logic [MV_W-1:0] ch0_low;
    logic [MV_W-1:0] ch0_high;
    logic [MV_W-1:0] ch1_low;
    logic [MV_W-1:0] ch1_high;
  } apdi_ext_t;

  // Window tracker status towards the top level.
  typedef struct packed {
    logic      close;
    apdi_ext_t ext;
  } apdi_win_sts_t;

endpackage

[design/apdi_window.sv]
// ----------------------------------------------------------------------------
// apdi_window
// Running minimum and maximum of both channels over one sample window.
// ----------------------------------------------------------------------------
module apdi_window (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  apdi_pkg::apdi_in_t             sample,
  output apdi_pkg::apdi_win_sts_t        sts
);

  apdi_pkg::apdi_ext_t                 ext_r;
  apdi_pkg::apdi_ext_t                 ext_nxt;
  apdi_pkg::apdi_ext_t                 ext_upd;
  logic [apdi_pkg::IDX_W-1:0]          idx_r;
  logic [apdi_pkg::IDX_W-1:0]          idx_nxt;
  logic [apdi_pkg::IDX_W:0]            idx_inc;
  logic                                close;

  // Fold the current sample into the stored extremes.
  always_comb begin
    ext_upd = ext_r;
    if (sample.ch0_mv < ext_r.ch0_low)  ext_upd.ch0_low  = sample.ch0_mv;
    if (sample.ch0_mv > ext_r.ch0_high) ext_upd.ch0_high = sample.ch0_mv;
    if (sample.ch1_mv < ext_r.ch1_low)  ext_upd.ch1_low  = sample.ch1_mv;
    if (sample.ch1_mv > ext_r.ch1_high) ext_upd.ch1_high = sample.ch1_mv;
  end

  // The window closes on its last sample.
  assign idx_inc = {1'b0, idx_r} + {{apdi_pkg::IDX_W{1'b0}}, 1'b1};
  assign close   = idx_inc >= (apdi_pkg::IDX_W+1)'(apdi_pkg::WINDOW);

  // A closing window restarts from empty extremes.
  always_comb begin
    ext_nxt = ext_r;
    idx_nxt = idx_r;
    if (step) begin
      if (close) begin
        ext_nxt.ch0_low  = apdi_pkg::MV_FULL;
        ext_nxt.ch0_high = '0;
        ext_nxt.ch1_low  = apdi_pkg::MV_FULL;
        ext_nxt.ch1_high = '0;
        idx_nxt          = '0;
      end else begin
        ext_nxt = ext_upd;
        idx_nxt = idx_inc[apdi_pkg::IDX_W-1:0];
      end
    end
  end

  // Window state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r.ch0_low  <= apdi_pkg::MV_FULL;
      ext_r.ch0_high <= '0;
      ext_r.ch1_low  <= apdi_pkg::MV_FULL;
      ext_r.ch1_high <= '0;
      idx_r          <= '0;
    end else begin
      ext_r <= ext_nxt;
      idx_r <= idx_nxt;
    end
  end

  assign sts.close = close;
  assign sts.ext   = ext_upd;

endmodule

[design/apdi_classify.sv]
// ----------------------------------------------------------------------------
// apdi_classify
// Classifies the spread and levels of a finished window.
// ----------------------------------------------------------------------------
module apdi_classify (
  input  apdi_pkg::apdi_ext_t   ext,
  output apdi_pkg::apdi_class_t cls
);

  logic [apdi_pkg::MV_W-1:0] d0;
  logic [apdi_pkg::MV_W-1:0] d1;
  logic                      ch0_flat;
  logic                      ch1_flat;
  logic                      ch1_flat_low;

  // Spreads of both channels, never negative.
  assign d0 = (ext.ch0_high >= ext.ch0_low) ? ext.ch0_high - ext.ch0_low : '0;
  assign d1 = (ext.ch1_high >= ext.ch1_low) ? ext.ch1_high - ext.ch1_low : '0;

  assign ch0_flat     = d0 < apdi_pkg::MV_FLAT;
  assign ch1_flat     = d1 < apdi_pkg::MV_FLAT;
  assign ch1_flat_low = ch1_flat && (ext.ch1_low <= apdi_pkg::MV_FLAT);

  // Decision tree; the first matching branch decides.
  always_comb begin
    cls = apdi_pkg::CLS_NONE;
    priority if (d1 >= apdi_pkg::MV_SERIAL_SPREAD) begin
      cls = apdi_pkg::CLS_SERIAL;
    end else if (ext.ch0_high >= apdi_pkg::MV_HIGH_LEVEL && ch0_flat) begin
      cls = ch1_flat_low ? apdi_pkg::CLS_TRAIN : apdi_pkg::CLS_NONE;
    end else if (ext.ch0_low <= apdi_pkg::MV_LOW_LEVEL && ch0_flat) begin
      if (ch1_flat_low) begin
        cls = apdi_pkg::CLS_SIMPLE;
      end else if (ext.ch1_low >= apdi_pkg::MV_MID_LEVEL && ch1_flat) begin
        cls = apdi_pkg::CLS_LIGHT;
      end
    end else begin
      cls = apdi_pkg::CLS_NONE;
    end
  end

endmodule

[design/analog_port_device_identifier_core.sv]
// ----------------------------------------------------------------------------
// analog_port_device_identifier_core
// Identifies the device on an analog port from windows of ID pin samples.
// ----------------------------------------------------------------------------
// The block takes one pair of ID pin voltages per clock cycle and gives one
// result at the end of every window of WINDOW samples; other samples give no
// result. An accepted sample lands in an input register; when it leaves that
// register, the window extremes are updated, and for a sample that closes
// its window the classification and the run count are updated together and
// the result is written to the output register. A sample is taken every
// cycle while the output register is free or the sample does not close a
// window. Samples above 5000 mV count as 5000 mV.
// The confirm threshold may be written at any idle moment.
module analog_port_device_identifier_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  apdi_pkg::apdi_in_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output apdi_pkg::apdi_out_t          out_data,
  input  logic                         cfg_wr_en,
  input  logic [apdi_pkg::CNT_W-1:0]   cfg_wr_data
);

  logic                         in_vld_r;
  apdi_pkg::apdi_in_t           in_dat_r;
  apdi_pkg::apdi_in_t           in_clamp;
  logic                         out_free;
  logic                         consume;
  logic                         in_take;
  apdi_pkg::apdi_win_sts_t      win_sts;
  apdi_pkg::apdi_class_t        cls;
  apdi_pkg::apdi_class_t        held_r;
  apdi_pkg::apdi_class_t        held_nxt;
  logic [apdi_pkg::CNT_W-1:0]   run_r;
  logic [apdi_pkg::CNT_W-1:0]   run_nxt;
  logic [apdi_pkg::CNT_W-1:0]   thresh_r;
  logic                         confirm;
  logic                         release_dev;
  logic                         out_vld_r;
  logic                         out_vld_nxt;
  apdi_pkg::apdi_out_t          out_dat_r;
  logic                         emit;

  // Saturate incoming samples at full scale.
  assign in_clamp.ch0_mv = (in_data.ch0_mv > apdi_pkg::MV_FULL) ? apdi_pkg::MV_FULL
                                                                  : in_data.ch0_mv;
  assign in_clamp.ch1_mv = (in_data.ch1_mv > apdi_pkg::MV_FULL) ? apdi_pkg::MV_FULL
                                                                  : in_data.ch1_mv;

  // Flow control: a closing sample needs room in the output register.
  assign out_free = !out_vld_r || !out_stall;
  assign consume  = in_vld_r && (!win_sts.close || out_free);
  assign emit     = consume && win_sts.close;
  assign in_stall = in_vld_r && !consume;
  assign in_take  = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_vld_r || consume) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_dat_r <= in_clamp;
    end
  end

  // Window extremes and classification.
  apdi_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (consume),
    .sample (in_dat_r),
    .sts    (win_sts)
  );

  apdi_classify u_classify (
    .ext (win_sts.ext),
    .cls (cls)
  );

  // Run count and held class update.
  always_comb begin
    held_nxt    = held_r;
    run_nxt     = run_r;
    release_dev = 1'b0;
    if (cls == apdi_pkg::CLS_NONE) begin
      run_nxt     = '0;
      release_dev = held_r != apdi_pkg::CLS_NONE;
      held_nxt    = apdi_pkg::CLS_NONE;
    end else if (held_r == cls) begin
      if (run_r != apdi_pkg::CNT_MAX) begin
        run_nxt = run_r + 8'd1;
      end
    end else begin
      held_nxt = cls;
      run_nxt  = '0;
    end
  end

  // Confirmation against the threshold of the class.
  always_comb begin
    unique case (cls)
      apdi_pkg::CLS_NONE:   confirm = 1'b0;
      apdi_pkg::CLS_SERIAL: confirm = run_nxt >= apdi_pkg::SERIAL_CONFIRM;
      default:              confirm = run_nxt >= thresh_r;
    endcase
  end

  // Tracking state and configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= apdi_pkg::CLS_NONE;
      run_r    <= '0;
      thresh_r <= apdi_pkg::THRESH_RESET;
    end else begin
      if (emit) begin
        held_r <= held_nxt;
        run_r  <= run_nxt;
      end
      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end
    end
  end

  // Output register.
  always_comb begin
    out_vld_nxt = out_vld_r && out_stall;
    if (emit) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_dat_r.detected_class <= cls;
      out_dat_r.confirmed      <= confirm;
      out_dat_r.release_device <= release_dev;
      out_dat_r.match_count    <= run_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_dat_r;

endmodule
